>>> design/ps2mpt_pkg.sv
// Shared constants for the PS/2 mouse packet tracker.
package ps2mpt_pkg;

    localparam int POS_W   = 16;
    localparam int DELTA_W = 17;
    localparam int BTN_W   = 3;
    localparam int MOVE_W  = 9;
    localparam int OUT_W   = 72;

    // Bit positions within the status byte.
    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;

    localparam logic signed [POS_W-1:0] RESET_X = 16'sd512;
    localparam logic signed [POS_W-1:0] RESET_Y = 16'sd384;
    localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7fff;
    localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic                      pad;
        logic signed [DELTA_W-1:0] delta_y;
        logic signed [DELTA_W-1:0] delta_x;
        logic                      packet_complete;
        logic                      moved;
        logic [BTN_W-1:0]          button_bits;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_x;
    } result_t;

endpackage

>>> design/ps2_mouse_packet_tracker_unit.sv
// PS/2 mouse packet tracker: packet assembly, position tracking and delta reads.
//
// Each input beat is either a byte from the mouse (tuser 0) or a request to read
// the movement since the previous read (tuser 1), and each yields one result beat.
// Bytes are gathered into three-byte packets; a first byte without sync bit 3 is
// dropped. The third byte latches the buttons and moves the position, which
// saturates at signed 16 bits and starts at (512, 384). A beat is held in the input
// register and then moves to the result register, from which its result is
// presented on the master side. A new beat is taken every cycle as long as the
// result side keeps up: the tracking state is updated in the same cycle the result
// is loaded.
module ps2_mouse_packet_tracker_unit
    import ps2mpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // rx_byte [7:0]
    input  logic             s_tuser,   // kind [0]
    output logic             m_tvalid,
    input  logic             m_tready,
    // pos_x [15:0], pos_y [31:16], button_bits [34:32], moved [35],
    // packet_complete [36], delta_x [53:37], delta_y [70:54], zero [71]
    output logic [OUT_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        PH_STATUS,
        PH_X,
        PH_Y
    } phase_t;

    logic                    in_valid_reg;
    logic                    kind_reg;
    logic [7:0]              byte_reg;
    logic                    out_valid_reg;
    result_t                 result_reg;
    result_t                 result_next;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [7:0]              status_reg;
    logic [7:0]              status_next;
    logic [7:0]              xbyte_reg;
    logic [7:0]              xbyte_next;
    logic signed [POS_W-1:0] pos_x_reg;
    logic signed [POS_W-1:0] pos_x_next;
    logic signed [POS_W-1:0] pos_y_reg;
    logic signed [POS_W-1:0] pos_y_next;
    logic [BTN_W-1:0]        buttons_reg;
    logic [BTN_W-1:0]        buttons_next;
    logic signed [POS_W-1:0] rep_x_reg;
    logic signed [POS_W-1:0] rep_x_next;
    logic signed [POS_W-1:0] rep_y_reg;
    logic signed [POS_W-1:0] rep_y_next;

    logic                    advance;
    logic signed [MOVE_W-1:0] dx;
    logic signed [MOVE_W-1:0] dy;
    logic signed [POS_W:0]   sum_x;
    logic signed [POS_W:0]   sum_y;
    logic signed [POS_W-1:0] sat_x;
    logic signed [POS_W-1:0] sat_y;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // Movement bytes carry their sign in the status byte, giving 9-bit values.
    assign dx = {status_reg[X_SIGN_BIT], xbyte_reg};
    assign dy = {status_reg[Y_SIGN_BIT], byte_reg};

    // A 17-bit sum overflowed when its top two bits disagree.
    assign sum_x = {pos_x_reg[POS_W-1], pos_x_reg}
                 + {{(POS_W-MOVE_W+1){dx[MOVE_W-1]}}, dx};
    assign sum_y = {pos_y_reg[POS_W-1], pos_y_reg}
                 - {{(POS_W-MOVE_W+1){dy[MOVE_W-1]}}, dy};
    assign sat_x = (sum_x[POS_W] != sum_x[POS_W-1]) ?
                   (sum_x[POS_W] ? POS_MIN : POS_MAX) : sum_x[POS_W-1:0];
    assign sat_y = (sum_y[POS_W] != sum_y[POS_W-1]) ?
                   (sum_y[POS_W] ? POS_MIN : POS_MAX) : sum_y[POS_W-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        status_next  = status_reg;
        xbyte_next   = xbyte_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        buttons_next = buttons_reg;
        rep_x_next   = rep_x_reg;
        rep_y_next   = rep_y_reg;

        result_next                 = '0;
        result_next.moved           = (pos_x_reg != rep_x_reg) || (pos_y_reg != rep_y_reg);
        result_next.packet_complete = 1'b0;

        if (kind_reg == KIND_READ)
        begin
            result_next.delta_x = {pos_x_reg[POS_W-1], pos_x_reg}
                                - {rep_x_reg[POS_W-1], rep_x_reg};
            result_next.delta_y = {pos_y_reg[POS_W-1], pos_y_reg}
                                - {rep_y_reg[POS_W-1], rep_y_reg};
            rep_x_next = pos_x_reg;
            rep_y_next = pos_y_reg;
        end
        else
        begin
            case (phase_reg)
                PH_X:
                begin
                    xbyte_next = byte_reg;
                    phase_next = PH_Y;
                end
                PH_Y:
                begin
                    buttons_next = status_reg[BTN_W-1:0];
                    pos_x_next   = sat_x;
                    pos_y_next   = sat_y;
                    phase_next   = PH_STATUS;
                    result_next.packet_complete = 1'b1;
                end
                default:
                begin
                    // A status byte must have its sync bit set, else it is dropped.
                    if (byte_reg[SYNC_BIT])
                    begin
                        status_next = byte_reg;
                        phase_next  = PH_X;
                    end
                    else
                    begin
                        phase_next = PH_STATUS;
                    end
                end
            endcase
        end

        result_next.pos_x       = pos_x_next;
        result_next.pos_y       = pos_y_next;
        result_next.button_bits = buttons_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            kind_reg      <= KIND_BYTE;
            byte_reg      <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
            phase_reg     <= PH_STATUS;
            status_reg    <= '0;
            xbyte_reg     <= '0;
            pos_x_reg     <= RESET_X;
            pos_y_reg     <= RESET_Y;
            buttons_reg   <= '0;
            rep_x_reg     <= RESET_X;
            rep_y_reg     <= RESET_Y;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                if (s_tvalid)
                begin
                    kind_reg <= s_tuser;
                    byte_reg <= s_tdata;
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                result_reg    <= result_next;
                phase_reg     <= phase_next;
                status_reg    <= status_next;
                xbyte_reg     <= xbyte_next;
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                buttons_reg   <= buttons_next;
                rep_x_reg     <= rep_x_next;
                rep_y_reg     <= rep_y_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // After a read beat is processed, the reference matches the position.
    a_read_syncs_ref: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (kind_reg == KIND_READ) |=>
            (pos_x_reg == rep_x_reg) && (pos_y_reg == rep_y_reg))
        else $error("reference not updated by read");

    // A finished packet never carries a delta.
    a_packet_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.packet_complete |->
            (result_reg.delta_x == '0) && (result_reg.delta_y == '0))
        else $error("delta reported with packet");

    // A beat held in the input register is not lost while the result side stalls.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(byte_reg) && $stable(kind_reg))
        else $error("stalled input beat lost");
`endif

endmodule
